@@ rtl/core/ksrd_pkg.sv @@
// ----------------------------------------------------------------------------
// ksrd_pkg
// Types, result codes and scan-code tables for the keyboard scan ring decoder.
// ----------------------------------------------------------------------------
package ksrd_pkg;

  typedef enum logic [3:0] {
    CODE_STORED    = 4'd0,
    CODE_DROPPED   = 4'd1,
    CODE_NO_DATA   = 4'd2,
    CODE_AUX       = 4'd3,
    CODE_LINE_ERR  = 4'd4,
    CODE_FAULT     = 4'd5,
    CODE_EVENT     = 4'd6,
    CODE_LOST      = 4'd7,
    CODE_EMPTY     = 4'd8,
    CODE_NOT_READY = 4'd9
  } code_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ctrl_status;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    code_t       code;
    logic [7:0]  scan_code;
    logic [6:0]  key_code;
    kind_t       event_kind;
    logic [5:0]  queued;
    logic [31:0] received_count;
    logic [31:0] dropped_count;
    logic [31:0] error_count;
    logic [31:0] aux_count;
  } out_beat_t;

  // controller status bits
  localparam int unsigned STS_DATA_BIT = 0;
  localparam int unsigned STS_AUX_BIT  = 5;
  localparam logic [7:0]  STS_ERR_MASK = 8'hc0;

  localparam logic [7:0] SCAN_EXT   = 8'he0;
  localparam logic [7:0] SCAN_PAUSE = 8'he1;
  localparam logic [2:0] PAUSE_LAST = 3'd5;

  // bytes that follow E1 in a pause run, indexed by position - 1
  function automatic logic [7:0] pause_byte(input logic [2:0] n);
    logic [7:0] b;
    case (n)
      3'd0:    b = 8'h1d;
      3'd1:    b = 8'h45;
      3'd2:    b = 8'he1;
      3'd3:    b = 8'h9d;
      default: b = 8'hc5;
    endcase
    return b;
  endfunction

  function automatic logic is_known_key(input logic [6:0] k);
    logic hit;
    case (k)
      7'h1e, 7'h30, 7'h2e, 7'h20,
      7'h39, 7'h1c, 7'h2a, 7'h36: hit = 1'b1;
      default:                    hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

@@ rtl/core/keyboard_scan_ring_decoder.sv @@
// ----------------------------------------------------------------------------
// keyboard_scan_ring_decoder
// Queues qualified controller bytes in a ring with a loss epoch and decodes
// dequeued bytes as set-1 scan codes on consumer polls.
// ----------------------------------------------------------------------------
//
//  channel | ports                       | beat
//  --------+-----------------------------+----------------------------------
//  in      | in_valid/in_ready/in_data   | controller byte or consumer poll
//  out     | out_valid/out_ready/out_data| one result per input beat
//  cfg     | cfg_valid/cfg_ready/cfg_data| enabled bit, always ready
//
//  One beat per cycle while in_ready is high: a beat is handled in the cycle it
//  is accepted and its result lands in the output register at that edge.
//  The ring memory read is registered; the entry at the tail is prefetched
//  into a read register, with write bypass, so a poll reads it without waiting.
//  in_ready follows the output register: low only while a result is stalled.
//  rst_n is synchronous; ring contents are not cleared.
// ----------------------------------------------------------------------------
module keyboard_scan_ring_decoder #(
  parameter int RING_DEPTH = 64,
  parameter int EPOCH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ksrd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ksrd_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int ENTRY_W = EPOCH_BITS + 8;
  localparam int OCC_W   = (PTR_W + 1 > 6) ? PTR_W + 1 : 6;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [ENTRY_W-1:0] ring_mem [RING_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  logic                  enabled_r;
  logic [PTR_W-1:0]      head_r, head_nxt, tail_r, tail_nxt, head_adv, tail_adv;
  logic [EPOCH_BITS-1:0] loss_ep_r, loss_ep_nxt, seen_ep_r, seen_ep_nxt, poll_ep;
  logic [31:0]           rcv_cnt_r, rcv_cnt_nxt, drop_cnt_r, drop_cnt_nxt;
  logic [31:0]           err_cnt_r, err_cnt_nxt, aux_cnt_r, aux_cnt_nxt;
  logic                  ext_r, ext_nxt;
  logic [2:0]            pause_r, pause_nxt;
  logic                  out_valid_r;
  ksrd_pkg::out_beat_t   out_r, res;

  logic                  in_acc, wr_en, ring_empty;
  logic [7:0]            deq_byte;
  logic [OCC_W-1:0]      occ;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign head_adv   = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_adv   = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign ring_empty = (head_r == tail_r);
  assign poll_ep    = ring_empty ? loss_ep_r : rd_data_r[ENTRY_W-1:8];
  assign deq_byte   = rd_data_r[7:0];

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    loss_ep_nxt  = loss_ep_r;
    seen_ep_nxt  = seen_ep_r;
    rcv_cnt_nxt  = rcv_cnt_r;
    drop_cnt_nxt = drop_cnt_r;
    err_cnt_nxt  = err_cnt_r;
    aux_cnt_nxt  = aux_cnt_r;
    ext_nxt      = ext_r;
    pause_nxt    = pause_r;
    wr_en        = 1'b0;
    res          = '0;
    res.code     = ksrd_pkg::CODE_NOT_READY;

    if (in_acc && enabled_r) begin
      if (in_data.op == ksrd_pkg::OP_BYTE) begin
        if (!in_data.ctrl_status[ksrd_pkg::STS_DATA_BIT]) begin
          res.code = ksrd_pkg::CODE_NO_DATA;
        end else if (in_data.ctrl_status[ksrd_pkg::STS_AUX_BIT]) begin
          if (&aux_cnt_r) begin
            res.code = ksrd_pkg::CODE_FAULT;
          end else begin
            aux_cnt_nxt = aux_cnt_r + 32'd1;
            res.code    = ksrd_pkg::CODE_AUX;
          end
        end else if (|(in_data.ctrl_status & ksrd_pkg::STS_ERR_MASK)) begin
          if ((&err_cnt_r) || (&loss_ep_r)) begin
            res.code = ksrd_pkg::CODE_FAULT;
          end else begin
            err_cnt_nxt = err_cnt_r + 32'd1;
            loss_ep_nxt = loss_ep_r + EPOCH_BITS'(1);
            res.code    = ksrd_pkg::CODE_LINE_ERR;
          end
        end else if ((&rcv_cnt_r) || (&drop_cnt_r) || (&loss_ep_r)) begin
          res.code = ksrd_pkg::CODE_FAULT;
        end else if (head_adv == tail_r) begin
          drop_cnt_nxt = drop_cnt_r + 32'd1;
          loss_ep_nxt  = loss_ep_r + EPOCH_BITS'(1);
          res.code     = ksrd_pkg::CODE_DROPPED;
        end else begin
          wr_en       = 1'b1;
          head_nxt    = head_adv;
          rcv_cnt_nxt = rcv_cnt_r + 32'd1;
          res.code    = ksrd_pkg::CODE_STORED;
        end
      end else begin
        if (poll_ep != seen_ep_r) begin
          seen_ep_nxt = poll_ep;
          ext_nxt     = 1'b0;
          pause_nxt   = '0;
          res.code    = ksrd_pkg::CODE_LOST;
        end else if (ring_empty) begin
          res.code = ksrd_pkg::CODE_EMPTY;
        end else begin
          tail_nxt      = tail_adv;
          res.code      = ksrd_pkg::CODE_EVENT;
          res.scan_code = deq_byte;
          // set-1 decode: pause run, then prefixes, then plain keys
          if (pause_r != '0) begin
            if (pause_r < ksrd_pkg::PAUSE_LAST &&
                deq_byte == ksrd_pkg::pause_byte(pause_r - 3'd1)) begin
              pause_nxt = pause_r + 3'd1;
            end else begin
              pause_nxt = '0;
            end
          end else if (deq_byte == ksrd_pkg::SCAN_PAUSE) begin
            ext_nxt   = 1'b0;
            pause_nxt = 3'd1;
          end else if (deq_byte == ksrd_pkg::SCAN_EXT) begin
            ext_nxt = 1'b1;
          end else if (ext_r) begin
            ext_nxt = 1'b0;
          end else if (ksrd_pkg::is_known_key(deq_byte[6:0])) begin
            res.key_code   = deq_byte[6:0];
            res.event_kind = deq_byte[7] ? ksrd_pkg::KIND_RELEASE : ksrd_pkg::KIND_PRESS;
          end
        end
      end
    end

    if (head_nxt >= tail_nxt) begin
      occ = OCC_W'(head_nxt) - OCC_W'(tail_nxt);
    end else begin
      occ = OCC_W'(head_nxt) + OCC_W'(RING_DEPTH) - OCC_W'(tail_nxt);
    end
    res.queued         = occ[5:0];
    res.received_count = rcv_cnt_nxt;
    res.dropped_count  = drop_cnt_nxt;
    res.error_count    = err_cnt_nxt;
    res.aux_count      = aux_cnt_nxt;
  end

  // ring memory; read port tracks the next tail, bypassing a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[head_r] <= {loss_ep_r, in_data.data_byte};
    end
    if (wr_en && head_r == tail_nxt) begin
      rd_data_r <= {loss_ep_r, in_data.data_byte};
    end else begin
      rd_data_r <= ring_mem[tail_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      loss_ep_r   <= '0;
      seen_ep_r   <= '0;
      rcv_cnt_r   <= '0;
      drop_cnt_r  <= '0;
      err_cnt_r   <= '0;
      aux_cnt_r   <= '0;
      ext_r       <= 1'b0;
      pause_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enabled_r <= cfg_data;
      end
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      loss_ep_r  <= loss_ep_nxt;
      seen_ep_r  <= seen_ep_nxt;
      rcv_cnt_r  <= rcv_cnt_nxt;
      drop_cnt_r <= drop_cnt_nxt;
      err_cnt_r  <= err_cnt_nxt;
      aux_cnt_r  <= aux_cnt_nxt;
      ext_r      <= ext_nxt;
      pause_r    <= pause_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res;
    end
  end

  // ---------------------------------------------------------------------------
  a_stored_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.code == ksrd_pkg::CODE_STORED) |=> (head_r != tail_r))
    else $error("ring empty right after a stored beat");

  a_disabled_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !enabled_r) |=> (out_r.code == ksrd_pkg::CODE_NOT_READY))
    else $error("disabled beat did not answer not ready");

  a_pause_range: assert property (@(posedge clk) disable iff (!rst_n)
    pause_r <= ksrd_pkg::PAUSE_LAST)
    else $error("pause position out of range");

  a_rcv_monotonic: assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> (rcv_cnt_r >= $past(rcv_cnt_r)))
    else $error("received count went backward");

  a_lost_syncs_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.code == ksrd_pkg::CODE_LOST) |=> (seen_ep_r == $past(poll_ep)))
    else $error("lost report did not record the epoch");

endmodule
